[src/trackball_quaternion_rotator_assert.svh]
// Assertion macros for the trackball quaternion rotator.
`ifndef TRACKBALL_QUATERNION_ROTATOR_ASSERT_SVH
`define TRACKBALL_QUATERNION_ROTATOR_ASSERT_SVH

// Same-cycle implication.
`define TQR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TQR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/trq_pkg.sv]
// Shared types, constants and helper functions for the trackball rotator.
package trq_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS = 14;
   localparam int QW = FRAC_BITS + 2;
   localparam int DIM_BITS = 13;
   localparam int DIV_NUM_BITS = 34;
   localparam int DIV_DEN_BITS = 16;
   localparam int FIFO_DEPTH = 2;

   localparam logic [63:0] GAIN_INV_Q32 = 64'h0000_0000_9B74_EDA8;
   localparam logic signed [19:0] CORDIC_X0 =
      20'((GAIN_INV_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_START = 2'd0;
   localparam cmd_type CMD_MOVE  = 2'd1;
   localparam cmd_type CMD_END   = 2'd2;
   localparam cmd_type CMD_INIT  = 2'd3;

   localparam logic REG_VIEW_WIDTH  = 1'b0;
   localparam logic REG_VIEW_HEIGHT = 1'b1;

   typedef logic [8:0][QW-1:0] mat_type;
   typedef logic [3:0][QW-1:0] quat_type;

   localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
   localparam mat_type IDENT_MAT = {ONE_Q, {3{QW'(0)}}, ONE_Q, {3{QW'(0)}}, ONE_Q};
   localparam quat_type IDENT_QUAT = {{3{QW'(0)}}, ONE_Q};

   typedef struct packed {
      cmd_type cmd;
      logic signed [COORD_BITS:0] diff_x;
      logic signed [COORD_BITS:0] diff_y;
   } item_type;

   typedef struct packed {
      logic start;
      logic [DIV_NUM_BITS-1:0] num;
      logic [DIV_DEN_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_NUM_BITS-1:0] quo;
   } div_rsp_type;

   function automatic logic signed [QW-1:0] sat_q(input logic signed [20:0] v);
      if (v > 21'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -21'sd32768) begin
         return 16'sh8000;
      end
      return v[QW-1:0];
   endfunction

   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      case (k)
         5'd0:  return 32'h20000000;
         5'd1:  return 32'h12E4051D;
         5'd2:  return 32'h09FB385B;
         5'd3:  return 32'h051111D4;
         5'd4:  return 32'h028B0D43;
         5'd5:  return 32'h0145D7E1;
         5'd6:  return 32'h00A2F61E;
         5'd7:  return 32'h00517C55;
         5'd8:  return 32'h0028BE53;
         5'd9:  return 32'h00145F2E;
         5'd10: return 32'h000A2F98;
         5'd11: return 32'h000517CC;
         5'd12: return 32'h00028BE6;
         5'd13: return 32'h000145F3;
         5'd14: return 32'h0000A2F9;
         5'd15: return 32'h0000517C;
         5'd16: return 32'h000028BE;
         5'd17: return 32'h0000145F;
         5'd18: return 32'h00000A2F;
         5'd19: return 32'h00000517;
         5'd20: return 32'h0000028B;
         5'd21: return 32'h00000145;
         5'd22: return 32'h000000A2;
         5'd23: return 32'h00000051;
         5'd24: return 32'h00000028;
         5'd25: return 32'h00000014;
         5'd26: return 32'h0000000A;
         5'd27: return 32'h00000005;
         5'd28: return 32'h00000002;
         5'd29: return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

endpackage

[src/trq_if.sv]
// Request and response channel interfaces.
interface trq_req_if;
   import trq_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   modport source (output valid, output command, output pos_x, output pos_y, input ready);
   modport sink (input valid, input command, input pos_x, input pos_y, output ready);
endinterface

interface trq_rsp_if;
   import trq_pkg::*;
   logic valid;
   logic ready;
   logic signed [QW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   modport source (output valid, input ready,
                   output m00, output m01, output m02, output m10, output m11,
                   output m12, output m20, output m21, output m22);
   modport sink (input valid, output ready,
                 input m00, input m01, input m02, input m10, input m11,
                 input m12, input m20, input m21, input m22);
endinterface

[src/trq_front.sv]
// Front end: takes request transfers, tracks the drag anchor, forms offsets.
module trq_front (
   input  logic clock,
   input  logic reset,
   trq_req_if.sink req_chan,
   input  logic fifo_full,
   output logic push,
   output trq_pkg::item_type push_item
);
   import trq_pkg::*;

   logic [COORD_BITS-1:0] anchor_x_ff, anchor_x_in;
   logic [COORD_BITS-1:0] anchor_y_ff, anchor_y_in;

   assign req_chan.ready = !fifo_full;
   assign push = req_chan.valid && !fifo_full;

   always_comb begin
      push_item.cmd = req_chan.command;
      push_item.diff_x = signed'({1'b0, req_chan.pos_x}) - signed'({1'b0, anchor_x_ff});
      push_item.diff_y = signed'({1'b0, req_chan.pos_y}) - signed'({1'b0, anchor_y_ff});
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      if (push && req_chan.command == CMD_START) begin
         anchor_x_in = req_chan.pos_x;
         anchor_y_in = req_chan.pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
      end else begin
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
      end
   end
endmodule

[src/trq_fifo.sv]
// Short queue of classified items between front and back end.
module trq_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  trq_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output logic valid,
   output trq_pkg::item_type head
);
   import trq_pkg::*;

   localparam int PtrW = $clog2(FIFO_DEPTH);
   localparam int CntW = $clog2(FIFO_DEPTH + 1);

   item_type mem [FIFO_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full = count_ff == CntW'(FIFO_DEPTH);
   assign valid = count_ff != '0;
   assign head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule

[src/trq_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module trq_div (
   input  logic clock,
   input  logic reset,
   input  trq_pkg::div_req_type req,
   output trq_pkg::div_rsp_type rsp
);
   import trq_pkg::*;

   localparam int CntW = $clog2(DIV_NUM_BITS + 1);

   logic busy_ff, busy_in, done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_NUM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_DEN_BITS:0] trial, diff;
   logic ge;

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      diff = trial - {1'b0, den_ff};
      ge = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = CntW'(DIV_NUM_BITS);
         rem_in = '0;
         den_in = req.den;
         quo_in = req.num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
         quo_in = {quo_ff[DIV_NUM_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

[src/trq_back.sv]
// Back end sequencer: drag math, CORDIC, quaternion product, matrix build.
module trq_back #(
   parameter int CORDIC_ITERS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic [trq_pkg::DIM_BITS-1:0] view_width,
   input  logic [trq_pkg::DIM_BITS-1:0] view_height,
   input  logic fifo_valid,
   input  trq_pkg::item_type fifo_item,
   output logic fifo_pop,
   output trq_pkg::div_req_type div_req,
   input  trq_pkg::div_rsp_type div_rsp,
   input  logic out_free,
   output logic out_load,
   output trq_pkg::mat_type out_mat
);
   import trq_pkg::*;

   localparam int IterW = $clog2(CORDIC_ITERS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV_GO   = 4'd1;
   localparam logic [3:0] S_DIV_WAIT = 4'd2;
   localparam logic [3:0] S_SQ1      = 4'd3;
   localparam logic [3:0] S_SQ2      = 4'd4;
   localparam logic [3:0] S_ROOT     = 4'd5;
   localparam logic [3:0] S_ANGLE    = 4'd6;
   localparam logic [3:0] S_CORDIC   = 4'd7;
   localparam logic [3:0] S_FOLD     = 4'd8;
   localparam logic [3:0] S_QMAC     = 4'd9;
   localparam logic [3:0] S_MMUL     = 4'd10;
   localparam logic [3:0] S_MSUM     = 4'd11;
   localparam logic [3:0] S_OUT      = 4'd12;

   logic [3:0] state_ff, state_in;
   item_type item_ff, item_in;
   logic [1:0] sel_ff, sel_in;
   logic neg_ff, neg_in;
   logic signed [QW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [QW-1:0] d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in;
   logic [31:0] sum_ff, sum_in, root_v_ff, root_v_in, root_r_ff, root_r_in;
   logic [3:0] root_cnt_ff, root_cnt_in;
   logic [QW-1:0] a_ff, a_in;
   logic [1:0] quad_ff, quad_in;
   logic signed [19:0] cx_ff, cx_in, cy_ff, cy_in, s_ff, s_in;
   logic signed [31:0] cz_ff, cz_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic [1:0] comp_ff, comp_in, term_ff, term_in;
   logic [3:0] step_ff, step_in;
   logic signed [20:0] acc_ff, acc_in;
   quat_type saved_ff, saved_in, cur_ff, cur_in;
   mat_type mat_ff, mat_in;
   logic signed [18:0] prod_ff [9];
   logic signed [18:0] prod_in [9];

   logic signed [19:0] mul_a, mul_b;
   logic signed [39:0] mul_p, mag_p, r14, r13;
   logic mul_neg;
   logic [COORD_BITS:0] mag_d;
   logic [DIM_BITS-1:0] dim;
   logic [32:0] root_t;
   logic [31:0] root_bit, phase, folded;
   logic [1:0] quad;
   logic [4:0] k;
   logic signed [19:0] xs, ys, fc, fs;
   logic signed [QW-1:0] qval;
   logic signed [20:0] term_v, one21;

   function automatic logic signed [19:0] ext20(input logic [QW-1:0] v);
      return 20'(signed'(v));
   endfunction

   function automatic logic signed [QW-1:0] sat_div(input logic neg,
                                                    input logic [DIV_NUM_BITS-1:0] quo);
      if (neg) begin
         if (quo > DIV_NUM_BITS'(32768)) begin
            return 16'sh8000;
         end
         return -signed'(quo[QW-1:0]);
      end
      if (quo > DIV_NUM_BITS'(32767)) begin
         return 16'sh7FFF;
      end
      return signed'(quo[QW-1:0]);
   endfunction

   assign mul_p = mul_a * mul_b;
   assign r14 = (mul_p + 40'sd8192) >>> FRAC_BITS;
   assign r13 = (mul_p + 40'sd4096) >>> (FRAC_BITS - 1);
   assign one21 = 21'(signed'({1'b0, ONE_Q}));

   assign fifo_pop = (state_ff == S_IDLE) && fifo_valid;
   assign out_load = (state_ff == S_OUT) && out_free;
   assign out_mat = mat_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_neg = 1'b0;
      case (state_ff)
         S_DIV_GO: begin
            mul_a = (sel_ff == 2'd2) ? 20'(dy_ff) : 20'(dx_ff);
            mul_b = s_ff;
         end
         S_SQ1: begin
            mul_a = 20'(dx_ff);
            mul_b = 20'(dx_ff);
         end
         S_SQ2: begin
            mul_a = 20'(dy_ff);
            mul_b = 20'(dy_ff);
         end
         S_QMAC: begin
            case (term_ff)
               2'd0: mul_a = 20'(d0_ff);
               2'd1: mul_a = 20'(d1_ff);
               default: mul_a = 20'(d2_ff);
            endcase
            case ({comp_ff, term_ff})
               4'h0: mul_b = ext20(saved_ff[0]);
               4'h1: begin mul_b = ext20(saved_ff[1]); mul_neg = 1'b1; end
               4'h2: begin mul_b = ext20(saved_ff[2]); mul_neg = 1'b1; end
               4'h4: mul_b = ext20(saved_ff[1]);
               4'h5: mul_b = ext20(saved_ff[0]);
               4'h6: mul_b = ext20(saved_ff[3]);
               4'h8: mul_b = ext20(saved_ff[2]);
               4'h9: begin mul_b = ext20(saved_ff[3]); mul_neg = 1'b1; end
               4'hA: mul_b = ext20(saved_ff[0]);
               4'hC: mul_b = ext20(saved_ff[3]);
               4'hD: mul_b = ext20(saved_ff[2]);
               4'hE: begin mul_b = ext20(saved_ff[1]); mul_neg = 1'b1; end
               default: mul_b = '0;
            endcase
         end
         S_MMUL: begin
            case (step_ff)
               4'd0: begin mul_a = ext20(cur_ff[1]); mul_b = ext20(cur_ff[1]); end
               4'd1: begin mul_a = ext20(cur_ff[2]); mul_b = ext20(cur_ff[2]); end
               4'd2: begin mul_a = ext20(cur_ff[3]); mul_b = ext20(cur_ff[3]); end
               4'd3: begin mul_a = ext20(cur_ff[1]); mul_b = ext20(cur_ff[2]); end
               4'd4: begin mul_a = ext20(cur_ff[2]); mul_b = ext20(cur_ff[3]); end
               4'd5: begin mul_a = ext20(cur_ff[3]); mul_b = ext20(cur_ff[1]); end
               4'd6: begin mul_a = ext20(cur_ff[1]); mul_b = ext20(cur_ff[0]); end
               4'd7: begin mul_a = ext20(cur_ff[2]); mul_b = ext20(cur_ff[0]); end
               default: begin mul_a = ext20(cur_ff[3]); mul_b = ext20(cur_ff[0]); end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      sel_in = sel_ff;
      neg_in = neg_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      d0_in = d0_ff;
      d1_in = d1_ff;
      d2_in = d2_ff;
      sum_in = sum_ff;
      root_v_in = root_v_ff;
      root_r_in = root_r_ff;
      root_cnt_in = root_cnt_ff;
      a_in = a_ff;
      quad_in = quad_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      s_in = s_ff;
      iter_in = iter_ff;
      comp_in = comp_ff;
      term_in = term_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      saved_in = saved_ff;
      cur_in = cur_ff;
      mat_in = mat_ff;
      prod_in = prod_ff;
      div_req = '0;

      mag_p = mul_p[39] ? -mul_p : mul_p;
      mag_d = '0;
      dim = '0;
      root_bit = 32'd1 << {root_cnt_ff, 1'b0};
      root_t = {1'b0, root_r_ff} + {1'b0, root_bit};
      phase = 32'({a_ff, 17'd0});
      folded = phase + 32'h2000_0000;
      quad = folded[31:30];
      k = 5'(iter_ff);
      xs = cx_ff >>> k;
      ys = cy_ff >>> k;
      fc = cx_ff;
      fs = cy_ff;
      qval = '0;
      term_v = mul_neg ? -21'(r14) : 21'(r14);

      case (state_ff)
         S_IDLE: begin
            if (fifo_valid) begin
               item_in = fifo_item;
               case (fifo_item.cmd)
                  CMD_MOVE: begin
                     sel_in = 2'd0;
                     state_in = S_DIV_GO;
                  end
                  CMD_END: begin
                     saved_in = cur_ff;
                     state_in = S_OUT;
                  end
                  CMD_INIT: begin
                     cur_in = saved_ff;
                     step_in = '0;
                     state_in = S_MMUL;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_DIV_GO: begin
            div_req.start = 1'b1;
            case (sel_ff)
               2'd0, 2'd1: begin
                  if (sel_ff == 2'd0) begin
                     mag_d = item_ff.diff_x[COORD_BITS] ? -item_ff.diff_x : item_ff.diff_x;
                     neg_in = item_ff.diff_x[COORD_BITS];
                     dim = (view_width == '0) ? DIM_BITS'(1) : view_width;
                  end else begin
                     mag_d = item_ff.diff_y[COORD_BITS] ? -item_ff.diff_y : item_ff.diff_y;
                     neg_in = item_ff.diff_y[COORD_BITS];
                     dim = (view_height == '0) ? DIM_BITS'(1) : view_height;
                  end
                  div_req.num = DIV_NUM_BITS'(mag_d[COORD_BITS-1:0]) << FRAC_BITS;
                  div_req.den = DIV_DEN_BITS'(dim);
               end
               default: begin
                  neg_in = mul_p[39];
                  div_req.num = mag_p[DIV_NUM_BITS-1:0];
                  div_req.den = a_ff;
               end
            endcase
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               qval = sat_div(neg_ff, div_rsp.quo);
               case (sel_ff)
                  2'd0: begin dx_in = qval; sel_in = 2'd1; state_in = S_DIV_GO; end
                  2'd1: begin dy_in = qval; state_in = S_SQ1; end
                  2'd2: begin d1_in = qval; sel_in = 2'd3; state_in = S_DIV_GO; end
                  default: begin
                     d2_in = qval;
                     comp_in = '0;
                     term_in = '0;
                     state_in = S_QMAC;
                  end
               endcase
            end
         end
         S_SQ1: begin
            sum_in = mul_p[31:0];
            state_in = S_SQ2;
         end
         S_SQ2: begin
            root_v_in = sum_ff + mul_p[31:0];
            root_r_in = '0;
            root_cnt_in = 4'd15;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if ({1'b0, root_v_ff} >= root_t) begin
               root_v_in = root_v_ff - root_t[31:0];
               root_r_in = (root_r_ff >> 1) + root_bit;
            end else begin
               root_r_in = root_r_ff >> 1;
            end
            root_cnt_in = root_cnt_ff - 1'b1;
            if (root_cnt_ff == '0) begin
               a_in = root_r_in[QW-1:0];
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            if (a_ff == '0) begin
               state_in = S_OUT;
            end else begin
               quad_in = quad;
               cz_in = signed'(phase - {quad, 30'd0});
               cx_in = CORDIC_X0;
               cy_in = '0;
               iter_in = '0;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (!cz_ff[31]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - signed'(atan_turn(k));
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + signed'(atan_turn(k));
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IterW'(CORDIC_ITERS - 1)) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            case (quad_ff)
               2'd0: begin fc = cx_ff;  fs = cy_ff;  end
               2'd1: begin fc = -cy_ff; fs = cx_ff;  end
               2'd2: begin fc = -cx_ff; fs = -cy_ff; end
               default: begin fc = cy_ff; fs = -cx_ff; end
            endcase
            d0_in = sat_q(21'(fc));
            s_in = fs;
            sel_in = 2'd2;
            state_in = S_DIV_GO;
         end
         S_QMAC: begin
            acc_in = ((term_ff == 2'd0) ? 21'sd0 : acc_ff) + term_v;
            if (term_ff == 2'd2) begin
               cur_in[comp_ff] = sat_q(acc_in);
               term_in = '0;
               comp_in = comp_ff + 1'b1;
               if (comp_ff == 2'd3) begin
                  step_in = '0;
                  state_in = S_MMUL;
               end
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         S_MMUL: begin
            prod_in[step_ff] = 19'(r13);
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd8) begin
               state_in = S_MSUM;
            end
         end
         S_MSUM: begin
            // x2 y2 z2 xy yz zx xw yw zw
            mat_in[0] = sat_q(one21 - 21'(prod_ff[1]) - 21'(prod_ff[2]));
            mat_in[1] = sat_q(21'(prod_ff[3]) + 21'(prod_ff[8]));
            mat_in[2] = sat_q(21'(prod_ff[5]) - 21'(prod_ff[7]));
            mat_in[3] = sat_q(21'(prod_ff[3]) - 21'(prod_ff[8]));
            mat_in[4] = sat_q(one21 - 21'(prod_ff[2]) - 21'(prod_ff[0]));
            mat_in[5] = sat_q(21'(prod_ff[4]) + 21'(prod_ff[6]));
            mat_in[6] = sat_q(21'(prod_ff[5]) + 21'(prod_ff[7]));
            mat_in[7] = sat_q(21'(prod_ff[4]) - 21'(prod_ff[6]));
            mat_in[8] = sat_q(one21 - 21'(prod_ff[0]) - 21'(prod_ff[1]));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sel_ff <= sel_in;
      neg_ff <= neg_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      d0_ff <= d0_in;
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      sum_ff <= sum_in;
      root_v_ff <= root_v_in;
      root_r_ff <= root_r_in;
      root_cnt_ff <= root_cnt_in;
      a_ff <= a_in;
      quad_ff <= quad_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      s_ff <= s_in;
      iter_ff <= iter_in;
      comp_ff <= comp_in;
      term_ff <= term_in;
      step_ff <= step_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= S_IDLE;
         saved_ff <= IDENT_QUAT;
         cur_ff <= '0;
         mat_ff <= IDENT_MAT;
      end else begin
         state_ff <= state_in;
         saved_ff <= saved_in;
         cur_ff <= cur_in;
         mat_ff <= mat_in;
      end
   end
endmodule

[src/trackball_quaternion_rotator.sv]
// Top level of the trackball quaternion rotator.
//
//   channel   dir  payload                      transfer when
//   req_chan  in   command, pos_x, pos_y        valid && ready
//   rsp_chan  out  m00 .. m22 (Q2.14)           valid && ready
//   csr_*     in   csr_index, csr_wdata         csr_write
//
// Start, end: straight to the output. Reinitialize: 9 products, one sum.
// Move: four divisions in the serial divider plus 16 square-root steps,
// CORDIC_ITERS CORDIC steps and the multiplier steps.
// Reset is synchronous; the queue of two items and the output register let the
// request side keep transferring while a response stalls.
module trackball_quaternion_rotator #(
   parameter int CORDIC_ITERS = 16
) (
   input  logic clock,
   input  logic reset,
   trq_req_if.sink req_chan,
   trq_rsp_if.source rsp_chan,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [trq_pkg::DIM_BITS-1:0] csr_wdata
);
   import trq_pkg::*;

   logic [DIM_BITS-1:0] view_width_ff, view_height_ff;
   logic push, fifo_full, fifo_valid, fifo_pop, out_free, out_load;
   item_type push_item, fifo_head;
   div_req_type div_req;
   div_rsp_type div_rsp;
   mat_type back_mat, rsp_mat_ff;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= DIM_BITS'(1024);
         view_height_ff <= DIM_BITS'(768);
      end else if (csr_write) begin
         if (csr_index == REG_VIEW_WIDTH) begin
            view_width_ff <= csr_wdata;
         end
         if (csr_index == REG_VIEW_HEIGHT) begin
            view_height_ff <= csr_wdata;
         end
      end
   end

   trq_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .fifo_full(fifo_full), .push(push), .push_item(push_item)
   );

   trq_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .full(fifo_full), .pop(fifo_pop), .valid(fifo_valid), .head(fifo_head)
   );

   trq_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   trq_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
      .clock(clock), .reset(reset),
      .view_width(view_width_ff), .view_height(view_height_ff),
      .fifo_valid(fifo_valid), .fifo_item(fifo_head), .fifo_pop(fifo_pop),
      .div_req(div_req), .div_rsp(div_rsp),
      .out_free(out_free), .out_load(out_load), .out_mat(back_mat)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mat_ff <= back_mat;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.m00 = rsp_mat_ff[0];
   assign rsp_chan.m01 = rsp_mat_ff[1];
   assign rsp_chan.m02 = rsp_mat_ff[2];
   assign rsp_chan.m10 = rsp_mat_ff[3];
   assign rsp_chan.m11 = rsp_mat_ff[4];
   assign rsp_chan.m12 = rsp_mat_ff[5];
   assign rsp_chan.m20 = rsp_mat_ff[6];
   assign rsp_chan.m21 = rsp_mat_ff[7];
   assign rsp_chan.m22 = rsp_mat_ff[8];
endmodule

[src/trq_chk.sv]
// Port-level checker for the trackball rotator, bound to the top level.
`include "trackball_quaternion_rotator_assert.svh"

module trq_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [15:0] rsp_m00,
   input logic [15:0] rsp_m11
);
   logic [2:0] pend_ff, pend_in;
   logic req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `TQR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_m00) && $stable(rsp_m11), "response changed while stalled")
   `TQR_ASSERT_IMP(a_no_extra_rsp, clock, reset, rsp_valid, pend_ff != 3'd0, "response without pending request")
   `TQR_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1, pend_ff <= 3'd4, "more items in flight than storage")
   `TQR_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")
endmodule

bind trackball_quaternion_rotator trq_chk u_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_m00(rsp_chan.m00),
   .rsp_m11(rsp_chan.m11)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the trackball quaternion rotator, with a scoreboard-based predictor.
module testbench;
   import trq_pkg::*;

   typedef logic [8:0][15:0] matrix_bits;

   class rotation_scoreboard;
      longint view_w, view_h, anc_x, anc_y;
      longint saved[4], cur[4], mat[9];
      matrix_bits expected_mats[$];
      int errors;
      longint atan_tab[16] = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                               32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                               32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                               32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

      function new();
         view_w = 1024;
         view_h = 768;
         anc_x = 0;
         anc_y = 0;
         foreach (saved[i]) begin
            saved[i] = 0;
            cur[i] = 0;
         end
         saved[0] = 16384;
         foreach (mat[i]) mat[i] = (i % 4 == 0) ? 16384 : 0;
         errors = 0;
      endfunction

      function void set_reg(logic idx, longint v);
         if (idx == REG_VIEW_WIDTH) view_w = v & 13'h1FFF;
         else view_h = v & 13'h1FFF;
      endfunction

      function longint sat16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint rmul(longint a, longint b);
         return (a * b + 8192) >>> 14;
      endfunction

      function longint rmul2(longint a, longint b);
         return (a * b + 4096) >>> 13;
      endfunction

      function void rebuild();
         longint x2, y2, z2, xy, yz, zx, xw, yw, zw;
         x2 = rmul2(cur[1], cur[1]); y2 = rmul2(cur[2], cur[2]); z2 = rmul2(cur[3], cur[3]);
         xy = rmul2(cur[1], cur[2]); yz = rmul2(cur[2], cur[3]); zx = rmul2(cur[3], cur[1]);
         xw = rmul2(cur[1], cur[0]); yw = rmul2(cur[2], cur[0]); zw = rmul2(cur[3], cur[0]);
         mat[0] = sat16(16384 - y2 - z2);
         mat[1] = sat16(xy + zw);
         mat[2] = sat16(zx - yw);
         mat[3] = sat16(xy - zw);
         mat[4] = sat16(16384 - z2 - x2);
         mat[5] = sat16(yz + xw);
         mat[6] = sat16(zx + yw);
         mat[7] = sat16(yz - xw);
         mat[8] = sat16(16384 - x2 - y2);
      endfunction

      function longint int_sqrt(longint v);
         longint res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else res = res >> 1;
            b = b >> 2;
         end
         return res;
      endfunction

      function longint scaled_delta(longint pos, longint anc, longint size);
         longint div;
         div = (size == 0) ? 1 : size;
         return sat16(((pos - anc) * 16384) / div);
      endfunction

      function void drag(longint px, longint py);
         longint dx, dy, a, x, y, z, xs, ys, c, s;
         longint d[4], sq[4];
         bit [31:0] p, quad, r;
         dx = scaled_delta(px, anc_x, view_w);
         dy = scaled_delta(py, anc_y, view_h);
         a = int_sqrt(dx * dx + dy * dy);
         if (a == 0) return;
         p = 32'(a << 17);
         quad = ((p + 32'h20000000) >> 30) & 32'd3;
         r = p - (quad << 30);
         z = longint'($signed(r));
         x = (64'h9B74EDA8 + (64'd1 << 17)) >> 18;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - atan_tab[i];
            end else begin
               x = x + ys; y = y - xs; z = z + atan_tab[i];
            end
         end
         case (quad)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         d[0] = sat16(c);
         d[1] = sat16((dy * s) / a);
         d[2] = sat16((dx * s) / a);
         d[3] = 0;
         sq = saved;
         cur[0] = sat16(rmul(d[0], sq[0]) - rmul(d[1], sq[1]) - rmul(d[2], sq[2])
                        - rmul(d[3], sq[3]));
         cur[1] = sat16(rmul(d[0], sq[1]) + rmul(d[1], sq[0]) + rmul(d[2], sq[3])
                        - rmul(d[3], sq[2]));
         cur[2] = sat16(rmul(d[0], sq[2]) - rmul(d[1], sq[3]) + rmul(d[2], sq[0])
                        + rmul(d[3], sq[1]));
         cur[3] = sat16(rmul(d[0], sq[3]) + rmul(d[1], sq[2]) - rmul(d[2], sq[1])
                        + rmul(d[3], sq[0]));
         rebuild();
      endfunction

      function void note_request(cmd_type cmd, longint px, longint py);
         matrix_bits m;
         case (cmd)
            CMD_START: begin anc_x = px; anc_y = py; end
            CMD_MOVE: drag(px, py);
            CMD_END: saved = cur;
            default: begin cur = saved; rebuild(); end
         endcase
         foreach (mat[i]) m[i] = 16'(mat[i]);
         expected_mats.push_back(m);
      endfunction

      function void check_matrix(matrix_bits got);
         matrix_bits want;
         if (expected_mats.size() == 0) begin
            $display("%0t: unexpected matrix transfer, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_mats.pop_front();
         for (int i = 0; i < 9; i++) begin
            if (got[i] !== want[i]) begin
               $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                        $signed(want[i]), $signed(got[i]));
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_mats.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic csr_index = REG_VIEW_WIDTH;
   logic [DIM_BITS-1:0] csr_wdata = '0;
   bit quiet = 0;
   bit long_hold = 0;
   int stall_left = 0;
   int sent = 0;
   rotation_scoreboard sb = new();

   trq_req_if req();
   trq_rsp_if rsp();

   trackball_quaternion_rotator uut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (long_hold) begin
         long_hold <= 0;
         stall_left <= 400;
         rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_matrix({rsp.m22, rsp.m21, rsp.m20, rsp.m12, rsp.m11, rsp.m10,
                          rsp.m02, rsp.m01, rsp.m00});
   end

   task automatic send(cmd_type cmd, int px, int py);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req.valid = 1'b1;
      req.command = cmd;
      req.pos_x = 12'(px);
      req.pos_y = 12'(py);
      do @(posedge clock); while (!req.ready);
      sb.note_request(cmd, px, py);
      sent++;
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_view(int w, int h);
      drain();
      csr_write = 1'b1;
      csr_index = REG_VIEW_WIDTH;
      csr_wdata = DIM_BITS'(w);
      @(negedge clock);
      sb.set_reg(REG_VIEW_WIDTH, w);
      csr_index = REG_VIEW_HEIGHT;
      csr_wdata = DIM_BITS'(h);
      @(negedge clock);
      sb.set_reg(REG_VIEW_HEIGHT, h);
      csr_write = 1'b0;
   endtask

   function automatic int near_pos(int base);
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 4095);
         1: v = base + $urandom_range(0, 8) - 4;
         default: v = base + $urandom_range(0, 600) - 300;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   task automatic random_items(int count);
      int ax, ay, stop;
      stop = sent + count;
      while (sent < stop) begin
         if ($urandom_range(0, 6) == 0) begin
            send(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 4095),
                 $urandom_range(0, 4095));
         end else begin
            ax = ($urandom_range(0, 7) == 0) ? 4095 * $urandom_range(0, 1)
                                              : $urandom_range(0, 4095);
            ay = ($urandom_range(0, 7) == 0) ? 4095 * $urandom_range(0, 1)
                                              : $urandom_range(0, 4095);
            send(CMD_START, ax, ay);
            repeat ($urandom_range(1, 6)) send(CMD_MOVE, near_pos(ax), near_pos(ay));
            if ($urandom_range(0, 4) != 0) send(CMD_END, $urandom_range(0, 4095),
                                                $urandom_range(0, 4095));
            else send(CMD_INIT, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.command = CMD_START;
      req.pos_x = '0;
      req.pos_y = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(CMD_INIT, 0, 0);
      send(CMD_END, 4095, 4095);
      send(CMD_INIT, 0, 0);
      send(CMD_START, 0, 0);
      send(CMD_MOVE, 0, 0);
      send(CMD_MOVE, 1, 0);
      send(CMD_MOVE, 0, 1);
      send(CMD_MOVE, 4095, 4095);
      send(CMD_END, 0, 0);
      send(CMD_START, 4095, 4095);
      send(CMD_MOVE, 0, 0);
      send(CMD_MOVE, 3000, 4095);
      send(CMD_INIT, 1234, 2345);
      send(CMD_MOVE, 4095, 0);
      send(CMD_END, 0, 0);
      send(CMD_START, 2048, 2048);
      send(CMD_MOVE, 2560, 2048);
      send(CMD_MOVE, 2048, 2432);

      set_view(1, 1);
      send(CMD_START, 0, 0);
      send(CMD_MOVE, 4095, 4095);
      send(CMD_MOVE, 0, 1);
      random_items(60);

      set_view(0, 0);
      random_items(50);

      set_view(8191, 4096);
      random_items(80);

      long_hold = 1;
      random_items(12);
      drain();
      random_items(20);

      set_view(4096, 1);
      random_items(80);

      set_view(1, 8191);
      random_items(60);

      for (int k = 0; k < 3; k++) begin
         set_view($urandom_range(0, 8191), $urandom_range(1, 4096));
         random_items(50);
      end

      set_view($urandom_range(200, 2000), $urandom_range(200, 2000));
      quiet = 1;
      random_items(80);

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
